FILE: rtl/clc_pkg.sv
// ----------------------------------------------------------------------------
// clc_pkg
// Shared types, constants and the microcode table for the card number
// classifier
// ----------------------------------------------------------------------------
package clc_pkg;

    localparam int CARD_W      = 54;
    localparam int MAX_DIGITS  = 16;
    localparam int BCD_DIGITS  = 17;
    localparam int BCD_W       = 4 * BCD_DIGITS;
    localparam int IDX_W       = 5;
    localparam int CNT_W       = 6;
    localparam int PC_W        = 3;

    typedef enum logic [1:0] {
        TYPE_INVALID = 2'd0,
        TYPE_AMEX    = 2'd1,
        TYPE_MASTER  = 2'd2,
        TYPE_VISA    = 2'd3
    } t_card_type;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_DABBLE,
        OP_SCAN,
        OP_FINISH
    } t_op;

    typedef enum logic [1:0] {
        CTR_HOLD,
        CTR_LOAD_BITS,
        CTR_LOAD_DIGITS,
        CTR_DEC
    } t_ctr;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_CNT_NZ,
        COND_OUT_FULL
    } t_cond;

    typedef struct packed {
        t_op              op;
        t_ctr             ctr;
        t_cond            cond;
        logic [PC_W-1:0]  target;
    } t_cword;

    typedef struct packed {
        t_op              op;
        logic [IDX_W-1:0] idx;
    } t_dp_ctrl;

    // program: take a number, shift-add-three, scan digits, hand over
    function automatic t_cword clc_rom(input logic [PC_W-1:0] pc);
        t_cword w;
        case (pc)
            3'd0:    w = '{OP_LOAD,   CTR_LOAD_BITS,   COND_NO_INPUT, 3'd0};
            3'd1:    w = '{OP_DABBLE, CTR_DEC,         COND_CNT_NZ,   3'd1};
            3'd2:    w = '{OP_NOP,    CTR_LOAD_DIGITS, COND_NEVER,    3'd0};
            3'd3:    w = '{OP_SCAN,   CTR_DEC,         COND_CNT_NZ,   3'd3};
            3'd4:    w = '{OP_FINISH, CTR_HOLD,        COND_OUT_FULL, 3'd4};
            3'd5:    w = '{OP_NOP,    CTR_HOLD,        COND_ALWAYS,   3'd0};
            default: w = '{OP_NOP,    CTR_HOLD,        COND_ALWAYS,   3'd0};
        endcase
        return w;
    endfunction

    // doubled digit with its digit sum folded in
    function automatic logic [3:0] luhn_double(input logic [3:0] d);
        logic [4:0] p;
        p = {d, 1'b0};
        if (p >= 5'd10) begin
            p = p - 5'd9;
        end
        return p[3:0];
    endfunction

endpackage

FILE: rtl/clc_card_if.sv
// ----------------------------------------------------------------------------
// clc_card_if
// Input channel: one card number per transaction
// ----------------------------------------------------------------------------
interface clc_card_if;
    import clc_pkg::*;

    logic              valid;
    logic              ready;
    logic [CARD_W-1:0] card_number;

    modport source (output valid, output card_number, input ready);
    modport sink   (input valid, input card_number, output ready);
endinterface

FILE: rtl/clc_result_if.sv
// ----------------------------------------------------------------------------
// clc_result_if
// Output channel: card type and checksum flag per transaction
// ----------------------------------------------------------------------------
interface clc_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] card_type;
    logic       checksum_ok;

    modport source (output valid, output card_type, output checksum_ok, input ready);
    modport sink   (input valid, input card_type, input checksum_ok, output ready);
endinterface

FILE: rtl/clc_datapath.sv
// ----------------------------------------------------------------------------
// clc_datapath
// Binary to BCD shift register, Luhn digit accumulator and prefix tracker,
// driven one control word per cycle
// ----------------------------------------------------------------------------
module clc_datapath
    import clc_pkg::*;
(
    input  logic              i_clk,
    input  t_dp_ctrl          i_ctrl,
    input  logic [CARD_W-1:0] i_card_number,
    output t_card_type        o_card_type,
    output logic              o_checksum_ok
);

    logic [CARD_W-1:0] r_bin,  n_bin;
    logic [BCD_W-1:0]  r_bcd,  n_bcd;
    logic [3:0]        r_sum,  n_sum;
    logic [IDX_W-1:0]  r_len,  n_len;
    logic [3:0]        r_prev, n_prev;
    logic [3:0]        r_msd,  n_msd;
    logic [3:0]        r_nsd,  n_nsd;

    logic [BCD_W-1:0]  adj;
    logic [3:0]        digit;
    logic [3:0]        term;
    logic [4:0]        acc;
    t_card_type        cls;

    always_comb begin
        for (int k = 0; k < BCD_DIGITS; k++) begin
            adj[4*k +: 4] = (r_bcd[4*k +: 4] >= 4'd5) ? r_bcd[4*k +: 4] + 4'd3
                                                       : r_bcd[4*k +: 4];
        end
        digit = r_bcd[3:0];
        term  = i_ctrl.idx[0] ? luhn_double(digit) : digit;
        acc   = {1'b0, r_sum} + {1'b0, term};

        n_bin  = r_bin;
        n_bcd  = r_bcd;
        n_sum  = r_sum;
        n_len  = r_len;
        n_prev = r_prev;
        n_msd  = r_msd;
        n_nsd  = r_nsd;
        case (i_ctrl.op)
            OP_LOAD: begin
                n_bin  = i_card_number;
                n_bcd  = '0;
                n_sum  = '0;
                n_len  = '0;
                n_prev = '0;
                n_msd  = '0;
                n_nsd  = '0;
            end
            OP_DABBLE: begin
                n_bcd = {adj[BCD_W-2:0], r_bin[CARD_W-1]};
                n_bin = {r_bin[CARD_W-2:0], 1'b0};
            end
            OP_SCAN: begin
                n_bcd  = {4'd0, r_bcd[BCD_W-1:4]};
                n_sum  = (acc >= 5'd10) ? 4'(acc - 5'd10) : acc[3:0];
                n_prev = digit;
                if (digit != 4'd0) begin
                    n_len = i_ctrl.idx + IDX_W'(1);
                    n_msd = digit;
                    n_nsd = r_prev;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_bin  <= n_bin;
        r_bcd  <= n_bcd;
        r_sum  <= n_sum;
        r_len  <= n_len;
        r_prev <= n_prev;
        r_msd  <= n_msd;
        r_nsd  <= n_nsd;
    end

    // class from length and leading two digits
    always_comb begin
        cls = TYPE_INVALID;
        if (r_len == IDX_W'(15) && r_msd == 4'd3 && (r_nsd == 4'd4 || r_nsd == 4'd7)) begin
            cls = TYPE_AMEX;
        end else if (r_len == IDX_W'(16) && r_msd == 4'd5 &&
                     r_nsd >= 4'd1 && r_nsd <= 4'd5) begin
            cls = TYPE_MASTER;
        end else if ((r_len == IDX_W'(13) || r_len == IDX_W'(16)) && r_msd == 4'd4) begin
            cls = TYPE_VISA;
        end
    end

    assign o_checksum_ok = (r_len <= IDX_W'(MAX_DIGITS)) && (r_sum == 4'd0);
    assign o_card_type   = o_checksum_ok ? cls : TYPE_INVALID;

endmodule

FILE: rtl/card_number_luhn_classifier.sv
// ----------------------------------------------------------------------------
// card_number_luhn_classifier
// Luhn mod-10 check and card type classification of a binary card number
// ----------------------------------------------------------------------------
// i_card carries one 54-bit card number per transaction, o_result returns
// one card type and checksum flag per number, both valid/ready.
// a small microcode program steps a datapath: it takes the number, runs
// shift-add-three steps over all 54 bits for the BCD conversion, sets up
// the digit counter, scans the 17 BCD digits, loads the output register
// and returns to the start. the BCD loop and the one-digit scan lane set
// the time per number.
// i_card.ready is high only in the program's first step.
// the output register holds its result until o_result.ready; while it is
// still full the program waits in its hand-over step, so a stalled
// receiver stalls the block after one finished result.
// reset clears the step counter and the output valid flag; the block is
// ready for a number in the first cycle after reset.
// ----------------------------------------------------------------------------
module card_number_luhn_classifier
    import clc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    clc_card_if.sink   i_card,
    clc_result_if.source o_result
);

    logic [PC_W-1:0]  r_pc,  n_pc;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid;
    logic [1:0]       r_out_type;
    logic             r_out_ok;

    t_cword     cw;
    t_dp_ctrl   dp_ctrl;
    t_card_type dp_type;
    logic       dp_ok;
    logic       out_full;
    logic       take;

    assign cw       = clc_rom(r_pc);
    assign out_full = r_out_valid && !o_result.ready;

    always_comb begin
        case (cw.cond)
            COND_NEVER:    take = 1'b0;
            COND_ALWAYS:   take = 1'b1;
            COND_NO_INPUT: take = !i_card.valid;
            COND_CNT_NZ:   take = (r_cnt != '0);
            COND_OUT_FULL: take = out_full;
            default:       take = 1'b0;
        endcase
        n_pc = take ? cw.target : r_pc + PC_W'(1);

        case (cw.ctr)
            CTR_HOLD:        n_cnt = r_cnt;
            CTR_LOAD_BITS:   n_cnt = CNT_W'(CARD_W - 1);
            CTR_LOAD_DIGITS: n_cnt = CNT_W'(BCD_DIGITS - 1);
            CTR_DEC:         n_cnt = r_cnt - CNT_W'(1);
            default:         n_cnt = r_cnt;
        endcase

        dp_ctrl.op  = (cw.op == OP_LOAD && !i_card.valid) ? OP_NOP : cw.op;
        dp_ctrl.idx = IDX_W'(BCD_DIGITS - 1) - r_cnt[IDX_W-1:0];
    end

    clc_datapath u_datapath (
        .i_clk         (i_clk),
        .i_ctrl        (dp_ctrl),
        .i_card_number (i_card.card_number),
        .o_card_type   (dp_type),
        .o_checksum_ok (dp_ok)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pc  <= n_pc;
            r_cnt <= n_cnt;
            if (cw.op == OP_FINISH && !out_full) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (cw.op == OP_FINISH && !out_full) begin
            r_out_type <= dp_type;
            r_out_ok   <= dp_ok;
        end
    end

    assign i_card.ready         = (cw.op == OP_LOAD);
    assign o_result.valid       = r_out_valid;
    assign o_result.card_type   = r_out_type;
    assign o_result.checksum_ok = r_out_ok;

endmodule

FILE: test/card_number_luhn_classifier_test.sv
// ----------------------------------------------------------------------------
// card_number_luhn_classifier_test
// Self-checking bench for the card number Luhn check and type classifier
// ----------------------------------------------------------------------------
// Card numbers go in on the input channel. A scoreboard predicts the Luhn
// verdict and card type of each accepted number and compares every returned
// result with the oldest prediction. Stimulus is a directed set around the
// prefix range bounds, then random numbers of each card shape, mostly with a
// corrected check digit. Both sides idle at random, with one stretch with no
// idling and one long receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class card_scoreboard;

    typedef struct {
        logic [clc_pkg::CARD_W-1:0] number;
        clc_pkg::t_card_type        kind;
        bit                         ok;
    } t_verdict;

    t_verdict verdicts[$];
    int       errors;

    function new();
        errors = 0;
    endfunction

    // luhn digit sum, doubling every second digit from the right
    static function int unsigned luhn_sum(input longint unsigned v,
                                          output int unsigned digits);
        int unsigned sum;
        int unsigned d;
        bit          dbl;
        sum    = 0;
        digits = 0;
        dbl    = 1'b0;
        while (v != 0) begin
            d = int'(v % 10);
            v = v / 10;
            if (dbl) begin
                d = d * 2;
                if (d >= 10) begin
                    d = d - 9;
                end
            end
            sum    = sum + d;
            dbl    = !dbl;
            digits = digits + 1;
        end
        return sum;
    endfunction

    static function bit in_span(input longint unsigned v, input longint unsigned lo,
                                input longint unsigned hi);
        return (v >= lo) && (v <= hi);
    endfunction

    function void note_number(input logic [clc_pkg::CARD_W-1:0] number);
        t_verdict        vd;
        longint unsigned v;
        int unsigned     digits;
        int unsigned     sum;
        v        = longint'(number);
        sum      = luhn_sum(v, digits);
        vd.number = number;
        vd.ok    = (digits <= clc_pkg::MAX_DIGITS) && (sum % 10 == 0);
        if (in_span(v, 64'd340000000000000, 64'd349999999999999) ||
            in_span(v, 64'd370000000000000, 64'd379999999999999)) begin
            vd.kind = clc_pkg::TYPE_AMEX;
        end else if (in_span(v, 64'd5100000000000000, 64'd5599999999999999)) begin
            vd.kind = clc_pkg::TYPE_MASTER;
        end else if (in_span(v, 64'd4000000000000, 64'd4999999999999) ||
                     in_span(v, 64'd4000000000000000, 64'd4999999999999999)) begin
            vd.kind = clc_pkg::TYPE_VISA;
        end else begin
            vd.kind = clc_pkg::TYPE_INVALID;
        end
        if (!vd.ok) begin
            vd.kind = clc_pkg::TYPE_INVALID;
        end
        verdicts.push_back(vd);
    endfunction

    task report(input string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    task check_result(input logic [1:0] kind, input logic ok);
        t_verdict vd;
        if (verdicts.size() == 0) begin
            report($sformatf("result type %0d ok %0d with no number pending", kind, ok));
        end else begin
            vd = verdicts.pop_front();
            if (kind !== vd.kind) begin
                report($sformatf("number %0d: card_type %0d, expected %0d",
                                 vd.number, kind, vd.kind));
            end
            if (ok !== vd.ok) begin
                report($sformatf("number %0d: checksum_ok %0d, expected %0d",
                                 vd.number, ok, vd.ok));
            end
        end
    endtask

    function int pending();
        return verdicts.size();
    endfunction

    task flush_leftovers();
        while (verdicts.size() != 0) begin
            report($sformatf("no result for number %0d", verdicts[0].number));
            void'(verdicts.pop_front());
        end
    endtask

endclass

module card_number_luhn_classifier_test;
    import clc_pkg::*;

    localparam longint unsigned RANGE_EDGES [10] = '{
        64'd340000000000000,  64'd349999999999999,
        64'd370000000000000,  64'd379999999999999,
        64'd5100000000000000, 64'd5599999999999999,
        64'd4000000000000,    64'd4999999999999,
        64'd4000000000000000, 64'd4999999999999999
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    clc_card_if   card_if ();
    clc_result_if res_if ();

    card_number_luhn_classifier dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_card   (card_if),
        .o_result (res_if)
    );

    card_scoreboard sb = new();

    int idle_pct      = 30;
    int hold_requests = 0;

    always #4 i_clk = ~i_clk;

    // replaces the last digit so that the luhn sum is a multiple of ten
    function automatic longint unsigned luhn_fix(input longint unsigned v);
        int unsigned digits;
        int unsigned sum;
        v   = v - (v % 10);
        sum = sb.luhn_sum(v, digits);
        return v + ((10 - (sum % 10)) % 10);
    endfunction

    function automatic longint unsigned rand_digits(input longint unsigned prefix,
                                                    input int prefix_len,
                                                    input int total_len);
        longint unsigned v;
        v = prefix;
        for (int i = prefix_len; i < total_len; i++) begin
            v = v * 10 + $urandom_range(0, 9);
        end
        return v;
    endfunction

    function automatic longint unsigned random_card();
        longint unsigned v;
        int              pfx;
        int              len;
        case ($urandom_range(0, 9))
            0, 1: begin
                pfx = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 38)
                                                  : (($urandom_range(0, 1) != 0) ? 34 : 37);
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 16) : 15;
                v   = rand_digits(pfx, 2, len);
            end
            2, 3: begin
                pfx = ($urandom_range(0, 9) == 0) ? $urandom_range(49, 57)
                                                  : $urandom_range(51, 55);
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 17) : 16;
                v   = rand_digits(pfx, 2, len);
            end
            4, 5: begin
                len = ($urandom_range(0, 1) != 0) ? 13 : 16;
                if ($urandom_range(0, 9) == 0) begin
                    len = $urandom_range(12, 17);
                end
                v = rand_digits(4, 1, len);
            end
            6: v = rand_digits($urandom_range(1, 9), 1, $urandom_range(1, 17));
            7: v = {$urandom, $urandom};
            8: begin
                v = RANGE_EDGES[$urandom_range(0, 9)];
                if ($urandom_range(0, 1) != 0) begin
                    v = v + $urandom_range(0, 20);
                end else begin
                    v = v - $urandom_range(0, 20);
                end
            end
            default: v = rand_digits($urandom_range(1, 9), 1, $urandom_range(12, 17));
        endcase
        v = v & ((64'd1 << CARD_W) - 1);
        if ($urandom_range(0, 99) < 75) begin
            v = luhn_fix(v) & ((64'd1 << CARD_W) - 1);
        end
        return v;
    endfunction

    // returns at the edge on which the number was taken
    task automatic send_card(input longint unsigned number);
        while ((idle_pct != 0) && ($urandom_range(0, 99) < idle_pct)) begin
            card_if.valid       <= 1'b0;
            card_if.card_number <= {$urandom, $urandom};
            @(posedge i_clk);
        end
        card_if.valid       <= 1'b1;
        card_if.card_number <= number[CARD_W-1:0];
        @(posedge i_clk);
        while (!card_if.ready) begin
            @(posedge i_clk);
        end
        sb.note_number(number[CARD_W-1:0]);
    endtask

    task automatic send_random(input int count);
        repeat (count) begin
            send_card(random_card());
        end
    endtask

    // receiver
    initial begin
        int served;
        int hold_left;
        served    = 0;
        hold_left = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                res_if.ready <= 1'b0;
                hold_left--;
            end else if (hold_requests != served) begin
                served        = hold_requests;
                hold_left     = 399;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= ($urandom_range(0, 99) >= idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            sb.check_result(res_if.card_type, res_if.checksum_ok);
        end
    end

    initial begin
        i_rst_n             <= 1'b0;
        card_if.valid       <= 1'b0;
        card_if.card_number <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // range bounds and their neighbours, all with a good check digit
        for (int i = 0; i < 10; i++) begin
            send_card(luhn_fix(RANGE_EDGES[i]));
            if (i % 2 == 0) begin
                send_card(luhn_fix(RANGE_EDGES[i] - 1));
            end else begin
                send_card(luhn_fix(RANGE_EDGES[i] + 1));
            end
        end
        send_card(64'd0);
        send_card((64'd1 << CARD_W) - 1);
        send_card(luhn_fix(64'd10000000000000000));
        send_card(64'd4111111111111112);
        send_card(64'd9999999999999999);

        send_random(400);

        // long receiver hold-off while numbers keep coming
        hold_requests++;
        send_random(200);

        idle_pct = 0;
        send_random(300);

        idle_pct = 30;
        send_random(300);

        @(posedge i_clk);
        card_if.valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (150) @(posedge i_clk);
        sb.flush_leftovers();
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #8ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: sim.f
rtl/clc_pkg.sv
rtl/clc_card_if.sv
rtl/clc_result_if.sv
rtl/clc_datapath.sv
rtl/card_number_luhn_classifier.sv
test/card_number_luhn_classifier_test.sv
